FILE: rtl/core/lic4_pkg.sv
// Package for the 4D lattice index converter.
// Holds field widths, the request codes and the divider cell step record.
// No dependencies.
package lic4_pkg;

   localparam int unsigned CoordW    = 10;
   localparam int unsigned LinW      = 31;
   localparam int unsigned CsrW      = 11;
   localparam int unsigned CsrIdxW   = 2;
   localparam int unsigned DefMaxExt = 1024;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_EXTENT_X = 2'd0,
      CSR_EXTENT_Y = 2'd1,
      CSR_EXTENT_Z = 2'd2
   } csr_idx_type;

   typedef enum logic {
      REQ_LINEARIZE = 1'b0,
      REQ_SPLIT     = 1'b1
   } req_kind_type;

   // control record handed down the chain beside the data
   typedef struct packed {
      logic valid;
      logic kind;
   } ctl_type;

endpackage

FILE: rtl/core/lic4_div_cell.sv
// One cell of the divider chain: one restoring quotient bit per cycle.
// Depends on lic4_pkg.
module lic4_div_cell
   import lic4_pkg::*;
#(
   parameter int unsigned DW  = 31,
   parameter int unsigned VW  = 11,
   parameter int unsigned BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl_i,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] quo_i,
   input  logic [VW-1:0] dvs_i,
   output ctl_type       ctl_o,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] quo_o,
   output logic [VW-1:0] dvs_o
);

   ctl_type       ctl_ff;
   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [VW-1:0] dvs_ff;
   logic [DW+VW-1:0] shifted;

   always_comb begin
      shifted = {{VW{1'b0}}, rem_i} >> BIT;
      rem_in  = rem_i;
      quo_in  = quo_i;
      if (shifted >= {{DW{1'b0}}, dvs_i}) begin
         // take the bit: subtract divisor at this position
         rem_in = rem_i - DW'({{DW{1'b0}}, dvs_i} << BIT);
         quo_in[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_i;
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign dvs_o = dvs_ff;

endmodule

FILE: rtl/core/lic4_divider.sv
// Pipelined restoring divider: a chain of DW cells, one quotient bit each.
// Depends on lic4_pkg and lic4_div_cell.
module lic4_divider
   import lic4_pkg::*;
#(
   parameter int unsigned DW = 31,
   parameter int unsigned VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl_i,
   input  logic [DW-1:0] dividend_i,
   input  logic [VW-1:0] divisor_i,
   output ctl_type       ctl_o,
   output logic [DW-1:0] quo_o,
   output logic [DW-1:0] rem_o
);

   ctl_type       ctl_c [DW+1];
   logic [DW-1:0] rem_c [DW+1];
   logic [DW-1:0] quo_c [DW+1];
   logic [VW-1:0] dvs_c [DW+1];

   assign ctl_c[0] = ctl_i;
   assign rem_c[0] = dividend_i;
   assign quo_c[0] = '0;
   assign dvs_c[0] = divisor_i;

   for (genvar g = 0; g < DW; g++) begin : g_cell
      lic4_div_cell #(.DW(DW), .VW(VW), .BIT(DW-1-g)) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl_c[g]),
         .rem_i (rem_c[g]),
         .quo_i (quo_c[g]),
         .dvs_i (dvs_c[g]),
         .ctl_o (ctl_c[g+1]),
         .rem_o (rem_c[g+1]),
         .quo_o (quo_c[g+1]),
         .dvs_o (dvs_c[g+1])
      );
   end

   assign ctl_o = ctl_c[DW];
   assign quo_o = quo_c[DW];
   assign rem_o = rem_c[DW];

   logic unused_dvs;
   assign unused_dvs = ^dvs_c[DW];

endmodule

FILE: rtl/core/lattice_index_converter_4d.sv
// Top level of the 4D lattice index converter.
// Depends on lic4_pkg, lic4_divider (and through it lic4_div_cell).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  request | req_type, req_coord_*, req_linear_in     | start high, busy low
//  result  | rsp_linear_out, rsp_out_*, rsp_overflow | done strobe, one cycle
//  config  | csr_we, csr_index, csr_wdata            | write on csr_we
//
// An item is taken every cycle; busy is tied low. Each item passes through
// three chains of 31 divider cells (x, y, z) plus one output register.
// Linearise items ride the same chain so order is kept.
// Reset clears the extents to 1 and all valid bits; the receiver cannot stall.
module lattice_index_converter_4d
   import lic4_pkg::*;
#(
   parameter int unsigned MAX_EXTENT = DefMaxExt
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [CoordW-1:0] req_coord_x,
   input  logic [CoordW-1:0] req_coord_y,
   input  logic [CoordW-1:0] req_coord_z,
   input  logic [CoordW-1:0] req_coord_t,
   input  logic [LinW-1:0]   req_linear_in,
   output logic              done,
   output logic [LinW-1:0]   rsp_linear_out,
   output logic [CoordW-1:0] rsp_out_x,
   output logic [CoordW-1:0] rsp_out_y,
   output logic [CoordW-1:0] rsp_out_z,
   output logic [LinW-1:0]   rsp_out_t,
   output logic              rsp_overflow,
   input  logic              csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrW-1:0]   csr_wdata
);

   localparam int unsigned ExtW  = $clog2(MAX_EXTENT + 1);
   localparam int unsigned Depth = 3 * LinW;
   localparam int unsigned ProdW = 2 * ExtW + LinW + 2;

   // extent registers
   logic [CsrW-1:0] ext_x_ff, ext_y_ff, ext_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= CsrW'(1);
         ext_y_ff <= CsrW'(1);
         ext_z_ff <= CsrW'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXTENT_X: ext_x_ff <= csr_wdata;
            CSR_EXTENT_Y: ext_y_ff <= csr_wdata;
            CSR_EXTENT_Z: ext_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective extent: zero reads as one, saturate at MAX_EXTENT
   function automatic logic [ExtW-1:0] eff_ext(input logic [CsrW-1:0] r);
      logic [ExtW+CsrW-1:0] w;
      w = {{ExtW{1'b0}}, r};
      if (r == '0) return ExtW'(1);
      if (w > (ExtW+CsrW)'(MAX_EXTENT)) return ExtW'(MAX_EXTENT);
      return ExtW'(w);
   endfunction

   logic [ExtW-1:0] lx, ly, lz;
   assign lx = eff_ext(ext_x_ff);
   assign ly = eff_ext(ext_y_ff);
   assign lz = eff_ext(ext_z_ff);

   assign busy = 1'b0;

   // linearise path: Horner form over registered stages riding alongside
   // the divider chain; ((t*lz + z)*ly + y)*lx + x, one multiply per stage
   ctl_type          in_ctl;
   assign in_ctl = '{valid: start, kind: req_type};

   logic [ProdW-1:0] h1_ff, h2_ff, h3_ff;
   logic [CoordW-1:0] hy1_ff, hx1_ff, hx2_ff;
   logic [ProdW-1:0] h1_in, h2_in, h3_in;

   assign h1_in = ProdW'(req_coord_t) * ProdW'(lz) + ProdW'(req_coord_z);
   always_ff @(posedge clock) begin
      h1_ff  <= h1_in;
      hy1_ff <= req_coord_y;
      hx1_ff <= req_coord_x;
      h2_ff  <= h2_in;
      hx2_ff <= hx1_ff;
      h3_ff  <= h3_in;
   end
   // cap the running value so the register stays narrow; any bit above 31
   // already means overflow and the low bits are preserved
   logic [ProdW-1:0] h1_cap;
   assign h1_cap = (h1_ff[ProdW-1:LinW+1] != '0) ?
                   {{(ProdW-LinW-1){1'b0}}, 1'b1, h1_ff[LinW-1:0]} : h1_ff;
   logic ovf1_ff, ovf2_ff;
   always_ff @(posedge clock) begin
      ovf1_ff <= (h1_ff[ProdW-1:LinW+1] != '0);
      ovf2_ff <= ovf1_ff | (h2_ff[ProdW-1:LinW+1] != '0);
   end
   assign h2_in = h1_cap * ProdW'(ly) + ProdW'(hy1_ff);
   logic [ProdW-1:0] h2_cap;
   assign h2_cap = (h2_ff[ProdW-1:LinW+1] != '0) ?
                   {{(ProdW-LinW-1){1'b0}}, 1'b1, h2_ff[LinW-1:0]} : h2_ff;
   assign h3_in = h2_cap * ProdW'(lx) + ProdW'(hx2_ff);

   logic [LinW-1:0] lin_res;
   logic            lin_ovf;
   assign lin_res = h3_ff[LinW-1:0];
   assign lin_ovf = ovf2_ff | (h3_ff[ProdW-1:LinW] != '0);

   // delay the linearise result to meet the split chain at its end
   localparam int unsigned LinDly = Depth - 3;
   logic [LinW-1:0] lin_dly_ff [LinDly];
   logic            ovf_dly_ff [LinDly];
   always_ff @(posedge clock) begin
      lin_dly_ff[0] <= lin_res;
      ovf_dly_ff[0] <= lin_ovf;
      for (int i = 1; i < LinDly; i++) begin
         lin_dly_ff[i] <= lin_dly_ff[i-1];
         ovf_dly_ff[i] <= ovf_dly_ff[i-1];
      end
   end

   // split path: x = idx % lx, then y, z from successive quotients
   ctl_type         c1, c2, c3;
   logic [LinW-1:0] q1, r1, q2, r2, q3, r3;
   logic [LinW-1:0] rx_ff [LinW];
   logic [LinW-1:0] ry_ff [LinW];

   lic4_divider #(.DW(LinW), .VW(ExtW)) u_div_x (
      .clock(clock), .reset(reset), .ctl_i(in_ctl), .dividend_i(req_linear_in),
      .divisor_i(lx), .ctl_o(c1), .quo_o(q1), .rem_o(r1));
   lic4_divider #(.DW(LinW), .VW(ExtW)) u_div_y (
      .clock(clock), .reset(reset), .ctl_i(c1), .dividend_i(q1),
      .divisor_i(ly), .ctl_o(c2), .quo_o(q2), .rem_o(r2));
   lic4_divider #(.DW(LinW), .VW(ExtW)) u_div_z (
      .clock(clock), .reset(reset), .ctl_i(c2), .dividend_i(q2),
      .divisor_i(lz), .ctl_o(c3), .quo_o(q3), .rem_o(r3));

   // hold earlier remainders until the last chain finishes
   always_ff @(posedge clock) begin
      rx_ff[0] <= r1;
      ry_ff[0] <= r2;
      for (int i = 1; i < LinW; i++) begin
         rx_ff[i] <= rx_ff[i-1];
         ry_ff[i] <= ry_ff[i-1];
      end
   end
   logic [LinW-1:0] rx_late;
   always_comb rx_late = rx_ff[LinW-1];
   logic [LinW-1:0] rx_at_end_ff [LinW];
   always_ff @(posedge clock) begin
      rx_at_end_ff[0] <= rx_late;
      for (int i = 1; i < LinW; i++) rx_at_end_ff[i] <= rx_at_end_ff[i-1];
   end

   // output register
   logic done_ff;
   logic [LinW-1:0] lin_ff, ot_ff;
   logic [CoordW-1:0] ox_ff, oy_ff, oz_ff;
   logic ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= c3.valid;
      end
      if (c3.kind == REQ_SPLIT) begin
         lin_ff <= '0;
         ovf_ff <= 1'b0;
         ox_ff  <= rx_at_end_ff[LinW-1][CoordW-1:0];
         oy_ff  <= ry_ff[LinW-1][CoordW-1:0];
         oz_ff  <= r3[CoordW-1:0];
         ot_ff  <= q3;
      end else begin
         lin_ff <= lin_dly_ff[LinDly-1];
         ovf_ff <= ovf_dly_ff[LinDly-1];
         ox_ff  <= '0;
         oy_ff  <= '0;
         oz_ff  <= '0;
         ot_ff  <= '0;
      end
   end

   assign done           = done_ff;
   assign rsp_linear_out = lin_ff;
   assign rsp_out_x      = ox_ff;
   assign rsp_out_y      = oy_ff;
   assign rsp_out_z      = oz_ff;
   assign rsp_out_t      = ot_ff;
   assign rsp_overflow   = ovf_ff;

`ifndef SYNTH
   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_split_no_ovf: assert property (@(posedge clock) disable iff (reset)
      done && rsp_out_t != '0 |-> !rsp_overflow)
      else $error("overflow on split item");
   a_lin_zero_coord: assert property (@(posedge clock) disable iff (reset)
      done && rsp_linear_out != '0 |-> rsp_out_t == '0 && rsp_out_x == '0)
      else $error("mixed result fields");
`endif

endmodule

FILE: dv/tb.sv
// Self-checking bench for lattice_index_converter_4d: coordinate/index conversion.
// Depends on lic4_pkg and the block; predicts each result and checks it on the done strobe.
`timescale 1ns / 1ps

module tb;
   import lic4_pkg::*;

   localparam int unsigned LATENCY   = 3 * LinW + 1;
   localparam longint      CYCLE_CAP = 400000;
   localparam int unsigned MAX_EXT   = DefMaxExt;

   typedef struct packed {
      logic [LinW-1:0]   lin;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] z;
      logic [LinW-1:0]   t;
      logic              ovf;
   } site_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_type = 1'b0;
   logic [CoordW-1:0] req_coord_x = '0;
   logic [CoordW-1:0] req_coord_y = '0;
   logic [CoordW-1:0] req_coord_z = '0;
   logic [CoordW-1:0] req_coord_t = '0;
   logic [LinW-1:0]   req_linear_in = '0;
   logic              done;
   logic [LinW-1:0]   rsp_linear_out;
   logic [CoordW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [LinW-1:0]   rsp_out_t;
   logic              rsp_overflow;
   logic              csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrW-1:0]   csr_wdata = '0;

   // predictor's copy of the extent registers
   logic [CsrW-1:0] extent_reg [3];

   site_result_type pending_sites[$];
   int      n_fail   = 0;
   int      n_linear = 0;
   int      n_split  = 0;
   int      n_ovf    = 0;
   longint  n_cycles = 0;

   lattice_index_converter_4d dut (.*);

   always #5 clock = ~clock;

   // Hold a cycle counter and give up well past the slowest correct run.
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Extent used by the block: zero reads as one, large values saturate.
   function automatic longint unsigned used_extent(logic [CsrW-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_EXT) return MAX_EXT;
      return r;
   endfunction

   function automatic site_result_type convert_site(logic kind, logic [CoordW-1:0] cx,
         logic [CoordW-1:0] cy, logic [CoordW-1:0] cz, logic [CoordW-1:0] ct,
         logic [LinW-1:0] idx);
      longint unsigned lx, ly, lz, pxy, pxyz, full;
      site_result_type r;
      lx = used_extent(extent_reg[0]);
      ly = used_extent(extent_reg[1]);
      lz = used_extent(extent_reg[2]);
      pxy = lx * ly;
      pxyz = pxy * lz;
      r = '0;
      if (kind == REQ_LINEARIZE) begin
         full = cx + cy * lx + cz * pxy + ct * pxyz;
         r.ovf = (full > 64'h7FFF_FFFF);
         r.lin = full[LinW-1:0];
      end else begin
         r.x = CoordW'(idx % lx);
         r.y = CoordW'((idx / lx) % ly);
         r.z = CoordW'((idx / pxy) % lz);
         r.t = LinW'(idx / pxyz);
      end
      return r;
   endfunction

   // Check each strobed result against the oldest prediction.
   always @(posedge clock) begin
      site_result_type want;
      if (!reset && done) begin
         if (pending_sites.size() == 0) begin
            $error("result with nothing expected");
            n_fail++;
         end else begin
            want = pending_sites.pop_front();
            if (rsp_linear_out !== want.lin) begin
               $error("linear_out exp %0d got %0d", want.lin, rsp_linear_out); n_fail++;
            end
            if (rsp_out_x !== want.x) begin
               $error("out_x exp %0d got %0d", want.x, rsp_out_x); n_fail++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y exp %0d got %0d", want.y, rsp_out_y); n_fail++;
            end
            if (rsp_out_z !== want.z) begin
               $error("out_z exp %0d got %0d", want.z, rsp_out_z); n_fail++;
            end
            if (rsp_out_t !== want.t) begin
               $error("out_t exp %0d got %0d", want.t, rsp_out_t); n_fail++;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("overflow exp %0d got %0d", want.ovf, rsp_overflow); n_fail++;
            end
         end
      end
   end

   // Drop start and drain the pipe fully; only then may an extent change.
   task automatic drain();
      start <= 1'b0;
      while (pending_sites.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_extent(csr_idx_type idx, logic [CsrW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      extent_reg[idx] = val;
   endtask

   task automatic set_extents(logic [CsrW-1:0] ex, logic [CsrW-1:0] ey, logic [CsrW-1:0] ez);
      drain();
      write_extent(CSR_EXTENT_X, ex);
      write_extent(CSR_EXTENT_Y, ey);
      write_extent(CSR_EXTENT_Z, ez);
   endtask

   // Present one item; it is taken at the next edge while busy is low.
   task automatic send_item(logic kind, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
         logic [CoordW-1:0] cz, logic [CoordW-1:0] ct, logic [LinW-1:0] idx);
      site_result_type r;
      start         <= 1'b1;
      req_type      <= kind;
      req_coord_x   <= cx;
      req_coord_y   <= cy;
      req_coord_z   <= cz;
      req_coord_t   <= ct;
      req_linear_in <= idx;
      do @(posedge clock); while (busy);
      r = convert_site(kind, cx, cy, cz, ct, idx);
      pending_sites.push_back(r);
      if (kind == REQ_LINEARIZE) n_linear++; else n_split++;
      if (r.ovf) n_ovf++;
   endtask

   task automatic idle_item();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Coordinates mostly inside the lattice, sometimes anywhere in the field.
   function automatic logic [CoordW-1:0] pick_coord(longint unsigned ext);
      if ($urandom_range(3) == 0) return CoordW'($urandom);
      return CoordW'($urandom_range(int'(ext) - 1));
   endfunction

   task automatic test_directed();
      set_extents(11'd1, 11'd1, 11'd1);
      send_item(REQ_LINEARIZE, '0, '0, '0, '0, '0);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'h7FFF_FFFF);
      set_extents(11'd1024, 11'd1024, 11'd1024);
      send_item(REQ_LINEARIZE, 10'd1023, 10'd1023, 10'd1023, 10'd1, '0);
      send_item(REQ_LINEARIZE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, '0);
      send_item(REQ_LINEARIZE, '0, '0, '0, 10'd2, '0);
      send_item(REQ_LINEARIZE, 10'd1023, 10'd1023, 10'd1023, 10'd1, '0);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'h7FFF_FFFF);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'd0);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'h2AAA_AAAA);
      // zero extents read as one, oversize extents saturate
      set_extents(11'd0, 11'h7FF, 11'd1025);
      send_item(REQ_LINEARIZE, 10'd5, 10'd7, 10'd9, 10'd3, '0);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'h5555_5555);
      // coordinates beyond their extents are weighted as given
      set_extents(11'd3, 11'd5, 11'd7);
      send_item(REQ_LINEARIZE, 10'd1023, 10'd600, 10'd1000, 10'd1023, '0);
      send_item(REQ_LINEARIZE, 10'h2AA, 10'h155, 10'h2AA, 10'h155, '0);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'd104);
      send_item(REQ_SPLIT, '0, '0, '0, '0, 31'd105);
      idle_item();
   endtask

   task automatic test_random(int n_items);
      logic [CsrW-1:0] ex, ey, ez;
      int sent, burst;
      sent = 0;
      while (sent < n_items) begin
         // change the lattice shape every so often, with a bias to small extents
         if (sent % 200 == 0) begin
            case ($urandom_range(3))
               0: ex = CsrW'($urandom);
               1: ex = CsrW'($urandom_range(1024));
               default: ex = CsrW'($urandom_range(16));
            endcase
            ey = ($urandom_range(3) == 0) ? CsrW'($urandom) : CsrW'($urandom_range(1, 40));
            ez = ($urandom_range(3) == 0) ? CsrW'($urandom) : CsrW'($urandom_range(40));
            set_extents(ex, ey, ez);
         end
         burst = ($urandom_range(4) == 0) ? 40 : $urandom_range(1, 12);
         repeat (burst) begin
            logic kind;
            logic [LinW-1:0] idx;
            kind = 1'($urandom_range(1));
            idx = ($urandom_range(2) == 0) ? LinW'($urandom)
                  : LinW'($urandom_range(used_extent(extent_reg[0])
                        * used_extent(extent_reg[1]) * 50));
            send_item(kind, pick_coord(used_extent(extent_reg[0])),
                      pick_coord(used_extent(extent_reg[1])),
                      pick_coord(used_extent(extent_reg[2])), CoordW'($urandom), idx);
            sent++;
         end
         // random gap, sometimes none at all
         if ($urandom_range(2) != 0) repeat ($urandom_range(1, 6)) idle_item();
      end
      idle_item();
   endtask

   initial begin
      extent_reg[0] = 1;
      extent_reg[1] = 1;
      extent_reg[2] = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1700);
      drain();
      $display("Covered %0d linearise and %0d split items, %0d with overflow.",
               n_linear, n_split, n_ovf);
      if (n_fail == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
